[rtl/sorted_list_engine_core_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef SORTED_LIST_ENGINE_CORE_MACROS_SVH
`define SORTED_LIST_ENGINE_CORE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sle_pkg.sv]
package sle_pkg;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_PREPEND = 3'd1;
  localparam logic [2:0] REQ_APPEND  = 3'd2;
  localparam logic [2:0] REQ_REMOVE  = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;
    logic cmp;
    logic exec;
    logic chk;
    logic fin;
  } sle_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sle_sts_t;

endpackage

[rtl/sle_ctrl.sv]
module sle_ctrl
  import sle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  sle_sts_t sts_i,
  output logic     idle_o,
  output sle_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/sle_dp.sv]
`include "sorted_list_engine_core_macros.svh"

module sle_dp
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sle_cmd_t           cmd_i,
  output sle_sts_t           sts_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] item_value_i,
  input  logic [3:0]         position_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] read_data_o,
  output logic [4:0]         entry_count_o,
  output logic               is_ascending_o,
  output logic               is_descending_o,
  output logic [1:0]         status_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  logic [2:0]         req_q;
  logic signed [31:0] val_q;
  logic [3:0]         pos_q;
  logic signed [31:0] ent_q [CAPACITY];
  logic signed [31:0] ent_d [CAPACITY];
  logic [CW-1:0]      count_q, count_d;
  logic [CAPACITY-1:0] ge_q, ge_d, stay;
  logic [CAPACITY-1:0] asc_q, desc_q, asc_d, desc_d;
  logic [1:0]         st_q, st_d;
  logic signed [31:0] rd_q, rd_d;
  logic               out_valid_q;
  logic [CW+4:0]      count_ext;
  logic [PW-1:0]      pos_w, count_w;
  logic               full, pos_ok;

  assign pos_w   = PW'(pos_q);
  assign count_w = PW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));
  assign pos_ok  = (pos_w < count_w);

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ge_d[k] = (CW'(k) < count_q) && (val_q >= ent_q[k]);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_before
    always_comb begin
      case (req_q)
        REQ_INSERT: stay[k] = &ge_q[k:0];
        REQ_APPEND: stay[k] = (CW'(k) < count_q);
        default:    stay[k] = 1'b0;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    st_d = ST_DONE;
    rd_d = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      ent_d[k] = ent_q[k];
    end
    case (req_q)
      REQ_INSERT, REQ_PREPEND, REQ_APPEND: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
          for (int k = 0; k < CAPACITY; k++) begin
            if (stay[k]) begin
              ent_d[k] = ent_q[k];
            end else if (k == 0) begin
              ent_d[k] = val_q;
            end else if (stay[k-1]) begin
              ent_d[k] = val_q;
            end else begin
              ent_d[k] = ent_q[k-1];
            end
          end
        end
      end
      REQ_REMOVE: begin
        if (!pos_ok) begin
          st_d = ST_RANGE;
        end else begin
          count_d = count_q - CW'(1);
          for (int k = 0; k < CAPACITY - 1; k++) begin
            if (PW'(k) >= pos_w) begin
              ent_d[k] = ent_q[k+1];
            end
          end
        end
      end
      REQ_READ: begin
        if (!pos_ok) begin
          st_d = ST_RANGE;
        end else begin
          for (int k = 0; k < CAPACITY && k < 16; k++) begin
            if (pos_q == 4'(k)) begin
              rd_d = ent_q[k];
            end
          end
        end
      end
      default: begin
        st_d = ST_DONE;
      end
    endcase
  end

  always_comb begin
    asc_d[0] = 1'b1;
    desc_d[0] = 1'b1;
    for (int k = 1; k < CAPACITY; k++) begin
      asc_d[k]  = (CW'(k) >= count_q) || (ent_q[k] >= ent_q[k-1]);
      desc_d[k] = (CW'(k) >= count_q) || (ent_q[k] <= ent_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      val_q <= item_value_i;
      pos_q <= position_i;
    end
    if (cmd_i.cmp) begin
      ge_q <= ge_d;
    end
    if (cmd_i.exec) begin
      for (int k = 0; k < CAPACITY; k++) begin
        ent_q[k] <= ent_d[k];
      end
      st_q <= st_d;
      rd_q <= rd_d;
    end
    if (cmd_i.chk) begin
      asc_q <= asc_d;
      desc_q <= desc_d;
    end
    if (cmd_i.fin) begin
      read_data_o <= rd_q;
      entry_count_o <= count_ext[4:0];
      is_ascending_o <= &asc_q;
      is_descending_o <= &desc_q;
      status_o <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext = {5'b0, count_q};
  assign out_valid_o = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  `SLE_ASSERT_ALWAYS(a_count_cap, clk_i, rst_ni, count_q <= CW'(CAPACITY), "count over capacity")
  `SLE_ASSERT_NEXT(a_full_hold, clk_i, rst_ni, cmd_i.exec && st_d == ST_FULL, count_q == CW'(CAPACITY), "full insert changed count")
  `SLE_ASSERT_NEXT(a_read_zero, clk_i, rst_ni, cmd_i.fin && st_q != ST_DONE, read_data_o == '0, "read data on failed request")

endmodule

[rtl/sorted_list_engine_core.sv]
// Sorted table engine. Requests enter on the s_axis channel, one item per
// request: tuser carries the request kind (insert sorted, prepend, append,
// remove at index, read at index), tdata carries the value and the index.
// Each request gives exactly one result item on the m_axis channel with the
// read value, entry count, ascending and descending flags and a status.
// An item is taken at a clock edge where tvalid and tready are both high.
// After a request is accepted it is handled in steps: compare the value against
// all entries, shift the entry cells in parallel, compare neighbors, and
// register the result, after which the result item is valid. Requests are
// handled one at a time, so a new request is taken only once the last one has
// registered its result.
// If the receiver stalls, the result register holds its item and the next
// request waits at the end of its work until the register is free.
// Reset clears the entry count and drops any pending result; entry storage
// is not cleared since only entries below the count are ever used.
`include "sorted_list_engine_core_macros.svh"

module sorted_list_engine_core
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // item_value[31:0], position[35:32], zero pad [39:36]
  input  logic [39:0] s_axis_tdata_i,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[31:0], entry_count[36:32], is_ascending[37], is_descending[38],
  // status[40:39], zero pad [47:41]
  output logic [47:0] m_axis_tdata_o
);

  sle_cmd_t           cmd;
  sle_sts_t           sts;
  logic               idle;
  logic               in_fire;
  logic signed [31:0] read_data;
  logic [4:0]         entry_count;
  logic               is_asc, is_desc;
  logic [1:0]         status;

  assign s_axis_tready_o = idle;
  assign in_fire = s_axis_tvalid_i && idle;

  sle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .sts_i     (sts),
    .idle_o    (idle),
    .cmd_o     (cmd)
  );

  sle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (s_axis_tuser_i),
    .item_value_i    (s_axis_tdata_i[31:0]),
    .position_i      (s_axis_tdata_i[35:32]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .read_data_o     (read_data),
    .entry_count_o   (entry_count),
    .is_ascending_o  (is_asc),
    .is_descending_o (is_desc),
    .status_o        (status)
  );

  assign m_axis_tdata_o = {7'b0, status, is_desc, is_asc, entry_count, read_data};

  `SLE_ASSERT_NEXT(a_no_accept_busy, clk_i, rst_ni, in_fire, !s_axis_tready_o, "accepted while busy")
  `SLE_ASSERT_ALWAYS(a_status_code, clk_i, rst_ni, !m_axis_tvalid_o || status != 2'd3, "bad status code")
  `SLE_ASSERT_ALWAYS(a_count_range, clk_i, rst_ni, !m_axis_tvalid_o || entry_count <= 5'(CAPACITY) || CAPACITY > 31, "count out of range")

endmodule

[tb/sv/sorted_list_engine_core_checker.sv]
`timescale 1ns / 100ps

module sorted_list_engine_core_checker
  import sle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_descending;
    logic               is_ascending;
    logic [4:0]         entry_count;
    logic signed [31:0] read_data;
  } table_result_t;

  logic signed [31:0] table_q [DEPTH];
  int                 table_count;
  table_result_t      expected_q [$];

  assign pending_o = expected_q.size();

  function automatic table_result_t apply_request(logic [2:0] kind,
                                                  logic signed [31:0] value,
                                                  logic [3:0] index);
    table_result_t r;
    int slot;
    r = '0;
    r.is_ascending = 1'b1;
    r.is_descending = 1'b1;
    if (kind == REQ_INSERT || kind == REQ_PREPEND || kind == REQ_APPEND) begin
      if (table_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = 0;
        if (kind == REQ_INSERT) begin
          while (slot < table_count && value >= table_q[slot]) slot++;
        end else if (kind == REQ_APPEND) begin
          slot = table_count;
        end
        for (int k = table_count; k > slot; k--) table_q[k] = table_q[k-1];
        table_q[slot] = value;
        table_count++;
      end
    end else if (kind == REQ_REMOVE || kind == REQ_READ) begin
      if (index >= table_count) begin
        r.status = ST_RANGE;
      end else if (kind == REQ_REMOVE) begin
        for (int k = index; k + 1 < table_count; k++) table_q[k] = table_q[k+1];
        table_count--;
      end else begin
        r.read_data = table_q[index];
      end
    end
    for (int k = 1; k < table_count; k++) begin
      if (table_q[k] < table_q[k-1]) r.is_ascending = 1'b0;
      if (table_q[k] > table_q[k-1]) r.is_descending = 1'b0;
    end
    r.entry_count = table_count[4:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t got;
    table_result_t want;
    if (!rst_ni) begin
      table_count = 0;
      expected_q.delete();
      fail_count_o = 0;
      results_seen_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[40:0];
        results_seen_o++;
        if (m_axis_tdata_i[47:41] != '0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("Nonzero padding in result item %0d.", results_seen_o);
        end
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("Unexpected result item: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("Mismatch at result %0d: expected data=%0d count=%0d asc=%b desc=%b st=%0d",
                       results_seen_o, want.read_data, want.entry_count, want.is_ascending,
                       want.is_descending, want.status);
              $display("  actual data=%0d count=%0d asc=%b desc=%b st=%0d",
                       got.read_data, got.entry_count, got.is_ascending,
                       got.is_descending, got.status);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_q.insert(expected_q.size(),
                          apply_request(s_axis_tuser_i, s_axis_tdata_i[31:0],
                                        s_axis_tdata_i[35:32]));
      end
    end
  end

endmodule

[tb/sv/sorted_list_engine_core_tb.sv]
`timescale 1ns / 100ps

module sorted_list_engine_core_tb
  import sle_pkg::*;
;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;

  int fail_count;
  int pending;
  int results_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int requests_sent;
  int model_count;

  sorted_list_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  sorted_list_engine_core_checker table_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_seen_o  (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls at random, or holds off entirely while hold_cycles runs down.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(logic [2:0] kind, logic [31:0] value, logic [3:0] index);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = {4'b0, index, value};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    requests_sent++;
    if (kind <= REQ_APPEND && model_count < 16) model_count++;
    if (kind == REQ_REMOVE && index < model_count) model_count--;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_requests(int n);
    logic [2:0] kind;
    logic [3:0] index;
    for (int i = 0; i < n; i++) begin
      // Bias toward growing the table when small and shrinking it when nearly full.
      if ($urandom_range(99) < 3) kind = 3'($urandom_range(7, 5));
      else if (model_count >= 14) kind = ($urandom_range(2) == 0) ?
                                         3'($urandom_range(2)) : 3'($urandom_range(4, 3));
      else if (model_count < 3) kind = ($urandom_range(3) == 0) ?
                                       3'($urandom_range(4, 3)) : 3'($urandom_range(2));
      else kind = 3'($urandom_range(4));
      if (model_count > 0 && $urandom_range(9) != 0) index = 4'($urandom_range(model_count - 1));
      else index = 4'($urandom);
      send_request(kind, pick_value(), index);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending != 0 || s_axis_tvalid_i) && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = REQ_INSERT;
    m_axis_tready_i = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    requests_sent = 0;
    model_count = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(REQ_READ, 32'd0, 4'd0);
    send_request(REQ_REMOVE, 32'd0, 4'd15);
    send_request(REQ_INSERT, 32'h7fff_ffff, 4'd0);
    send_request(REQ_INSERT, 32'h8000_0000, 4'd0);
    send_request(REQ_INSERT, 32'd5, 4'd0);
    send_request(REQ_INSERT, 32'd5, 4'd0);
    send_request(REQ_PREPEND, 32'hffff_ffff, 4'd0);
    send_request(REQ_APPEND, 32'h0, 4'd0);
    send_request(REQ_READ, 32'hffff_ffff, 4'd0);
    send_request(REQ_READ, 32'd0, 4'd5);
    send_request(REQ_READ, 32'd0, 4'd6);
    send_request(3'd5, 32'hffff_ffff, 4'hf);
    send_request(3'd6, 32'd1, 4'd1);
    send_request(3'd7, 32'd2, 4'd2);
    send_request(REQ_REMOVE, 32'd0, 4'd0);
    send_request(REQ_REMOVE, 32'd0, 4'd4);
    for (int i = 0; i < 13; i++) send_request(REQ_APPEND, 32'(i * 77 - 400), 4'd0);
    send_request(REQ_INSERT, 32'd1, 4'd0);
    send_request(REQ_READ, 32'd0, 4'd15);
    for (int i = 0; i < 16; i++) send_request(REQ_REMOVE, 32'd0, 4'd0);
    drain();

    random_requests(400);
    drain();
    send_idle_pct = 81;
    random_requests(300);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 81;
    random_requests(300);
    drain();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    hold_cycles = 300;
    random_requests(350);
    drain();

    $display("Sent %0d requests and checked %0d results across insert, prepend, append,",
             requests_sent, results_seen);
    $display("remove and read, with full-table and out-of-range cases under idle and stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_ctrl.sv
rtl/sle_dp.sv
rtl/sorted_list_engine_core.sv
tb/sv/sorted_list_engine_core_checker.sv
tb/sv/sorted_list_engine_core_tb.sv
